// ----- hw/rtl/ppuf_pkg.sv -----
// Package: shared types, constants and codes for the persistence pair union-find block
`default_nettype none
package ppuf_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int VIDX_W       = $clog2(VERTEX_COUNT);
  localparam int VALUE_W      = 32;
  localparam int THR_W        = 31;
  localparam int STEP_W       = VIDX_W + 1;
  localparam int NEXT_W       = VIDX_W + 1;

  localparam logic [STEP_W-1:0]  STEP_MAX = STEP_W'(VERTEX_COUNT);
  localparam logic [NEXT_W-1:0]  LIST_END = NEXT_W'(VERTEX_COUNT);
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_QVERT = 2'd2,
    MODE_QPERM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PAIR = 2'd0,
    KIND_VERT = 2'd1,
    KIND_PERM = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [VIDX_W-1:0]         vertex_a;
    logic [VIDX_W-1:0]         vertex_b;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] birth_value;
    logic signed [VALUE_W-1:0] death_value;
    logic                      death_infinite;
    logic [VIDX_W-1:0]         vertex;
    logic [VIDX_W-1:0]         parent_vertex;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_QRY_RD, S_QRY_OUT, S_PERM,
    S_FA_RD, S_FA_CK, S_FB_RD, S_FB_CK,
    S_BA_RD, S_BB_RD, S_BR1, S_BR2, S_DEC, S_PAIR,
    S_FL_WR, S_FL_CK, S_LINK, S_LINK2, S_LINK3
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_QRY_RD, OP_QRY_OUT, OP_PERM,
    OP_FA_RD, OP_FA_CK, OP_FB_RD, OP_FB_CK,
    OP_BA_RD, OP_BB_RD, OP_BR1, OP_BR2, OP_DEC, OP_PAIR,
    OP_FL_WR, OP_FL_CK, OP_LINK, OP_LINK2, OP_LINK3
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic list_done;
    logic same_root;
    logic emit_pair;
    logic do_flatten;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ppuf_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module ppuf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ppuf_ctrl.sv -----
// Controller: sequencing state machine for load, edge, and query words
`default_nettype none
module ppuf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       mode,
  input  wire ppuf_pkg::status_t status,
  output ppuf_pkg::cmd_t         cmd,
  output logic                  busy
);
  import ppuf_pkg::*;

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // advance state and issue datapath command
  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (mode_t'(mode))
            MODE_LOAD:  state_next = S_LOAD;
            MODE_EDGE:  state_next = S_FA_RD;
            MODE_QVERT: state_next = S_QRY_RD;
            MODE_QPERM: state_next = S_PERM;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op = OP_LOAD;
        state_next = S_IDLE;
      end
      S_QRY_RD: begin
        cmd.op = OP_QRY_RD;
        state_next = S_QRY_OUT;
      end
      S_QRY_OUT: begin
        cmd.op = OP_QRY_OUT;
        state_next = S_IDLE;
      end
      S_PERM: begin
        cmd.op = OP_PERM;
        state_next = S_IDLE;
      end
      S_FA_RD: begin
        cmd.op = OP_FA_RD;
        state_next = S_FA_CK;
      end
      S_FA_CK: begin
        cmd.op = OP_FA_CK;
        state_next = status.root_done ? S_FB_RD : S_FA_RD;
      end
      S_FB_RD: begin
        cmd.op = OP_FB_RD;
        state_next = S_FB_CK;
      end
      S_FB_CK: begin
        cmd.op = OP_FB_CK;
        state_next = status.root_done ? S_BA_RD : S_FB_RD;
      end
      S_BA_RD: begin
        cmd.op = OP_BA_RD;
        state_next = S_BB_RD;
      end
      S_BB_RD: begin
        cmd.op = OP_BB_RD;
        state_next = S_BR1;
      end
      S_BR1: begin
        cmd.op = OP_BR1;
        state_next = S_BR2;
      end
      S_BR2: begin
        cmd.op = OP_BR2;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.op = OP_DEC;
        state_next = status.same_root ? S_IDLE : S_PAIR;
      end
      S_PAIR: begin
        cmd.op = OP_PAIR;
        state_next = (status.emit_pair && status.do_flatten) ? S_FL_WR : S_LINK;
      end
      S_FL_WR: begin
        cmd.op = OP_FL_WR;
        state_next = S_FL_CK;
      end
      S_FL_CK: begin
        cmd.op = OP_FL_CK;
        state_next = status.list_done ? S_LINK : S_FL_WR;
      end
      S_LINK: begin
        cmd.op = OP_LINK;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        cmd.op = OP_LINK2;
        state_next = S_LINK3;
      end
      S_LINK3: begin
        cmd.op = OP_LINK3;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_dec_from_br2: assert property (@(posedge clk) disable iff (rst)
    state == S_DEC |-> $past(state) == S_BR2)
    else $error("root compare reached without both birth reads");

endmodule
`default_nettype wire

// ----- hw/rtl/ppuf_dp.sv -----
// Datapath: vertex stores, walk registers, minimum tracking and result register
`default_nettype none
module ppuf_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ppuf_pkg::in_word_t            item,
  input  wire ppuf_pkg::cmd_t                cmd,
  input  wire logic                          cfg_we,
  input  wire logic [ppuf_pkg::THR_W-1:0]    cfg_wdata,
  output ppuf_pkg::status_t                  status,
  output logic                               result_valid,
  output ppuf_pkg::out_word_t                result
);
  import ppuf_pkg::*;

  // captured word
  logic [1:0]                mode_q;
  logic [VIDX_W-1:0]         va, vb;
  logic signed [VALUE_W-1:0] val;

  // walk and edge registers
  logic [VIDX_W-1:0]         x, ra, rb, up, vp, tvp;
  logic [STEP_W-1:0]         steps;
  logic signed [VALUE_W-1:0] ba, bb, bra, bup, death;
  logic [THR_W-1:0]          thr;
  logic signed [VALUE_W-1:0] min_value;
  logic [VIDX_W-1:0]         min_index;

  // RAM ports
  logic                      b_we, l_we, r_we, p_we, n_we, t_we;
  logic [VIDX_W-1:0]         b_wa, l_wa, r_wa, p_wa, n_wa, t_wa;
  logic [VIDX_W-1:0]         b_ra, t_ra;
  logic [VALUE_W-1:0]        b_wd, l_wd, b_rd, l_rd;
  logic [VIDX_W-1:0]         r_wd, p_wd, t_wd, r_rd, p_rd, t_rd;
  logic [NEXT_W-1:0]         n_wd, n_rd;
  logic signed [VALUE_W:0]   diff;
  logic                      ra_younger;

  ppuf_ram #(.WIDTH(VALUE_W), .DEPTH(VERTEX_COUNT)) u_birth (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  ppuf_ram #(.WIDTH(VALUE_W), .DEPTH(VERTEX_COUNT)) u_level (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(va), .rdata(l_rd));
  ppuf_ram #(.WIDTH(VIDX_W), .DEPTH(VERTEX_COUNT)) u_root (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(x), .rdata(r_rd));
  ppuf_ram #(.WIDTH(VIDX_W), .DEPTH(VERTEX_COUNT)) u_mparent (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(va), .rdata(p_rd));
  ppuf_ram #(.WIDTH(NEXT_W), .DEPTH(VERTEX_COUNT)) u_mnext (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(x), .rdata(n_rd));
  ppuf_ram #(.WIDTH(VIDX_W), .DEPTH(VERTEX_COUNT)) u_mtail (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

  // persistence of the younger root, always positive when a pair is emitted
  assign diff       = {death[VALUE_W-1], death} - {bup[VALUE_W-1], bup};
  assign ra_younger = !($signed(bra) < $signed(b_rd));

  assign status.root_done  = (r_rd == x) || (steps == STEP_MAX);
  assign status.list_done  = n_rd[NEXT_W-1] || (steps == STEP_MAX);
  assign status.same_root  = (ra == rb);
  assign status.emit_pair  = (bup < death);
  assign status.do_flatten = (diff < $signed({2'b00, thr}));

  // drive RAM write and read ports from the command
  always_comb begin
    b_we = 1'b0; l_we = 1'b0; r_we = 1'b0; p_we = 1'b0; n_we = 1'b0; t_we = 1'b0;
    b_wa = va;   l_wa = va;   r_wa = va;   p_wa = va;   n_wa = va;   t_wa = va;
    b_wd = val;  l_wd = val;  r_wd = va;   p_wd = va;   n_wd = LIST_END; t_wd = va;
    b_ra = va;
    t_ra = vp;
    case (cmd.op)
      OP_LOAD: begin
        b_we = 1'b1; l_we = 1'b1; r_we = 1'b1; p_we = 1'b1; n_we = 1'b1; t_we = 1'b1;
      end
      OP_BB_RD: b_ra = vb;
      OP_BR1:   b_ra = ra;
      OP_BR2:   b_ra = rb;
      OP_FL_WR: begin
        l_we = 1'b1;
        l_wa = x;
        l_wd = death;
      end
      OP_LINK: begin
        r_we = 1'b1; r_wa = up; r_wd = vp;
        p_we = 1'b1; p_wa = up; p_wd = vp;
      end
      OP_LINK2: t_ra = up;
      OP_LINK3: begin
        n_we = 1'b1; n_wa = tvp; n_wd = {1'b0, up};
        t_we = 1'b1; t_wa = vp;  t_wd = t_rd;
      end
      default: ;
    endcase
  end

  // hold threshold and minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= '0;
      min_value <= VALUE_MAX;
      min_index <= '0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (cmd.op == OP_LOAD && val < min_value) begin
        min_value <= val;
        min_index <= va;
      end
    end
  end

  // capture word, walk links, decide roots
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= item.mode;
      va     <= item.vertex_a;
      vb     <= item.vertex_b;
      val    <= item.value;
      x      <= item.vertex_a;
      steps  <= '0;
    end
    case (cmd.op)
      OP_FA_CK: begin
        if (status.root_done) begin
          ra    <= x;
          x     <= vb;
          steps <= '0;
        end else begin
          x     <= r_rd;
          steps <= steps + 1'b1;
        end
      end
      OP_FB_CK: begin
        if (status.root_done) begin
          rb <= x;
        end else begin
          x     <= r_rd;
          steps <= steps + 1'b1;
        end
      end
      OP_BB_RD: ba  <= b_rd;
      OP_BR1:   bb  <= b_rd;
      OP_BR2: begin
        bra   <= b_rd;
        death <= (ba > bb) ? ba : bb;
      end
      OP_DEC: begin
        if (ra_younger) begin
          up  <= ra;
          vp  <= rb;
          bup <= bra;
        end else begin
          up  <= rb;
          vp  <= ra;
          bup <= b_rd;
        end
      end
      OP_PAIR: begin
        x     <= up;
        steps <= '0;
      end
      OP_FL_WR: steps <= steps + 1'b1;
      OP_FL_CK: x     <= n_rd[VIDX_W-1:0];
      OP_LINK2: tvp   <= t_rd;
      default: ;
    endcase
  end

  // register the result word for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == OP_QRY_OUT) || (cmd.op == OP_PERM) ||
                      (cmd.op == OP_PAIR && status.emit_pair);
    end
    case (cmd.op)
      OP_QRY_OUT: begin
        result.kind           <= KIND_VERT;
        result.birth_value    <= l_rd;
        result.death_value    <= '0;
        result.death_infinite <= 1'b0;
        result.vertex         <= va;
        result.parent_vertex  <= p_rd;
      end
      OP_PERM: begin
        result.kind           <= KIND_PERM;
        result.birth_value    <= min_value;
        result.death_value    <= '0;
        result.death_infinite <= 1'b1;
        result.vertex         <= min_index;
        result.parent_vertex  <= min_index;
      end
      OP_PAIR: begin
        result.kind           <= KIND_PAIR;
        result.birth_value    <= bup;
        result.death_value    <= death;
        result.death_infinite <= 1'b0;
        result.vertex         <= up;
        result.parent_vertex  <= vp;
      end
      default: ;
    endcase
  end

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_PAIR |-> result.birth_value < result.death_value)
    else $error("pair emitted with birth not below death");

  a_perm_inf: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind == KIND_PERM) == result.death_infinite)
    else $error("infinite death flag disagrees with kind");

  a_mode_edge: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DEC |-> mode_q == MODE_EDGE)
    else $error("root compare on a non-edge word");

endmodule
`default_nettype wire

// ----- hw/rtl/persistence_pair_union_find_top.sv -----
// Top level: zero-dimensional persistence pairing by union-find
//
// One word is taken at a time: busy stays high until the word is done. An edge
// walks the links from each endpoint to its root, one link at a time. When the
// roots differ it emits a pair if the younger root was born below the death
// value, flattens the dying component's region member by member when that
// pair's persistence is under the threshold, and links the roots; the single
// read port of each link store sets this pace.
// A result appears on result for exactly one cycle with result_valid high and
// cannot be held off; it may overlap the start of the next word.
`default_nettype none
module persistence_pair_union_find_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire ppuf_pkg::in_word_t         item,
  input  wire logic                       cfg_we,
  input  wire logic [ppuf_pkg::THR_W-1:0] cfg_wdata,
  output logic                            result_valid,
  output ppuf_pkg::out_word_t             result
);
  import ppuf_pkg::*;

  cmd_t    cmd;
  status_t status;

  ppuf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(item.mode),
    .status(status), .cmd(cmd), .busy(busy));

  ppuf_dp u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .status(status),
    .result_valid(result_valid), .result(result));

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for persistence_pair_union_find_top: random union-find traffic checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

class pair_scoreboard;
  // predictor state, mirrors the block's stores
  logic signed [31:0] birth [1024];
  logic signed [31:0] level [1024];
  logic [9:0]         root_link [1024];
  logic [9:0]         merge_par [1024];
  logic [10:0]        member_next [1024];
  logic [9:0]         member_tail [1024];
  logic signed [31:0] min_val;
  logic [9:0]         min_idx;
  logic [30:0]        flatten_thr;
  ppuf_pkg::out_word_t expected_words [$];
  int                 fail_count;

  function new();
    min_val     = 32'sh7FFF_FFFF;
    min_idx     = '0;
    flatten_thr = '0;
    fail_count  = 0;
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  function logic [9:0] find_root(logic [9:0] x);
    int steps;
    steps = 0;
    while (root_link[x] != x && steps < ppuf_pkg::VERTEX_COUNT) begin
      x = root_link[x];
      steps++;
    end
    return x;
  endfunction

  // advance the predicted state by one accepted word
  function void note_word(ppuf_pkg::in_word_t w);
    ppuf_pkg::out_word_t r;
    logic [9:0]          a, b, up, vp, t;
    logic signed [31:0]  death;
    logic [10:0]         walk;
    longint              diff;
    int                  steps;
    a = w.vertex_a;
    b = w.vertex_b;
    r = '0;
    case (w.mode)
      ppuf_pkg::MODE_LOAD: begin
        birth[a]       = w.value;
        level[a]       = w.value;
        root_link[a]   = a;
        merge_par[a]   = a;
        member_next[a] = ppuf_pkg::LIST_END;
        member_tail[a] = a;
        if (w.value < min_val) begin
          min_val = w.value;
          min_idx = a;
        end
      end
      ppuf_pkg::MODE_EDGE: begin
        up = find_root(a);
        vp = find_root(b);
        death = (birth[a] > birth[b]) ? birth[a] : birth[b];
        if (up != vp) begin
          if (birth[up] < birth[vp]) begin
            t = up;
            up = vp;
            vp = t;
          end
          if (birth[up] < death) begin
            r.kind          = ppuf_pkg::KIND_PAIR;
            r.birth_value   = birth[up];
            r.death_value   = death;
            r.vertex        = up;
            r.parent_vertex = vp;
            expected_words.push_back(r);
            diff = longint'(death) - longint'(birth[up]);
            // raise the whole dying component to the death level
            if (diff < longint'({1'b0, flatten_thr})) begin
              walk = {1'b0, up};
              steps = 0;
              while (walk != ppuf_pkg::LIST_END && steps < ppuf_pkg::VERTEX_COUNT) begin
                level[walk[9:0]] = death;
                walk = (member_next[walk[9:0]] >= ppuf_pkg::LIST_END) ?
                       ppuf_pkg::LIST_END : member_next[walk[9:0]];
                steps++;
              end
            end
          end
          root_link[up] = vp;
          merge_par[up] = vp;
          member_next[member_tail[vp]] = {1'b0, up};
          member_tail[vp] = member_tail[up];
        end
      end
      ppuf_pkg::MODE_QVERT: begin
        r.kind          = ppuf_pkg::KIND_VERT;
        r.birth_value   = level[a];
        r.vertex        = a;
        r.parent_vertex = merge_par[a];
        expected_words.push_back(r);
      end
      default: begin
        r.kind           = ppuf_pkg::KIND_PERM;
        r.birth_value    = min_val;
        r.death_infinite = 1'b1;
        r.vertex         = min_idx;
        r.parent_vertex  = min_idx;
        expected_words.push_back(r);
      end
    endcase
  endfunction

  function void report(string field, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // compare one result word with the oldest expectation
  function void check_result(ppuf_pkg::out_word_t got);
    ppuf_pkg::out_word_t e;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %0h", $realtime, got);
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    report("kind", e.kind, got.kind);
    report("birth_value", e.birth_value, got.birth_value);
    report("death_value", e.death_value, got.death_value);
    report("death_infinite", e.death_infinite, got.death_infinite);
    report("vertex", e.vertex, got.vertex);
    report("parent_vertex", e.parent_vertex, got.parent_vertex);
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] key;
    logic [9:0]         va;
    logic [9:0]         vb;
  } edge_rec_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  ppuf_pkg::in_word_t         item;
  logic                       cfg_we;
  logic [ppuf_pkg::THR_W-1:0] cfg_wdata;
  logic                       result_valid;
  ppuf_pkg::out_word_t        result;

  pair_scoreboard sb = new();
  int             cycles = 0;
  int             burst_left = 0;
  int             words_sent = 0;
  bit             is_loaded [1024];
  logic [9:0]     loaded_q [$];
  logic signed [31:0] load_val [1024];

  persistence_pair_union_find_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid), .result(result)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("persistence_pair_union_find_top verification failed");
      $finish;
    end
  end

  // check each result word on the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // hand one word to the block in bursts with random gaps
  task automatic issue_word(ppuf_pkg::in_word_t w);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    words_sent++;
    if (w.mode == ppuf_pkg::MODE_LOAD && !is_loaded[w.vertex_a]) begin
      is_loaded[w.vertex_a] = 1'b1;
      loaded_q.push_back(w.vertex_a);
    end
    if (w.mode == ppuf_pkg::MODE_LOAD) load_val[w.vertex_a] = w.value;
  endtask

  task automatic send(ppuf_pkg::mode_t m, logic [9:0] a, logic [9:0] b, logic [31:0] v);
    ppuf_pkg::in_word_t w;
    w.mode     = m;
    w.vertex_a = a;
    w.vertex_b = b;
    w.value    = v;
    issue_word(w);
  endtask

  // drain, let the block settle, then write the threshold
  task automatic write_threshold(logic [30:0] thr);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.flatten_thr = thr;
  endtask

  function automatic logic [9:0] any_loaded();
    return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
  endfunction

  // one well-formed filtration over a fresh vertex group, plus some noise
  task automatic run_group();
    logic [9:0]         verts [$];
    edge_rec_t          edges [$];
    edge_rec_t          tmp;
    logic signed [31:0] base;
    logic [9:0]         v;
    int                 n, ne, i, j;
    bit                 narrow;
    n = $urandom_range(2, 10);
    narrow = $urandom_range(0, 2) != 0;
    base = $urandom;
    for (i = 0; i < n; i++) begin
      v = 10'($urandom_range(0, 1023));
      verts.push_back(v);
      send(ppuf_pkg::MODE_LOAD, v, 10'($urandom),
           narrow ? base + $urandom_range(0, 32'h0003_0000) : $urandom);
    end
    ne = $urandom_range(n - 1, 2 * n);
    for (i = 0; i < ne; i++) begin
      tmp.va = verts[$urandom_range(0, n - 1)];
      tmp.vb = ($urandom_range(0, 7) == 0) ? any_loaded() : verts[$urandom_range(0, n - 1)];
      tmp.key = (load_val[tmp.va] > load_val[tmp.vb]) ? load_val[tmp.va] : load_val[tmp.vb];
      edges.push_back(tmp);
    end
    // order by death unless this group is a broken filtration
    if ($urandom_range(0, 4) != 0) begin
      for (i = 1; i < edges.size(); i++) begin
        tmp = edges[i];
        j = i - 1;
        while (j >= 0 && edges[j].key > tmp.key) begin
          edges[j + 1] = edges[j];
          j--;
        end
        edges[j + 1] = tmp;
      end
    end
    foreach (edges[k]) begin
      send(ppuf_pkg::MODE_EDGE, edges[k].va, edges[k].vb, $urandom);
      if ($urandom_range(0, 3) == 0)
        send(ppuf_pkg::MODE_QVERT, verts[$urandom_range(0, n - 1)], 10'($urandom), $urandom);
    end
    foreach (verts[k]) send(ppuf_pkg::MODE_QVERT, verts[k], 10'($urandom), $urandom);
    send(ppuf_pkg::MODE_QPERM, 10'($urandom), 10'($urandom), $urandom);
    if ($urandom_range(0, 3) == 0)
      send(ppuf_pkg::MODE_LOAD, any_loaded(), 10'($urandom), $urandom);
    if ($urandom_range(0, 2) == 0)
      send(ppuf_pkg::MODE_EDGE, any_loaded(), any_loaded(), $urandom);
  endtask

  initial begin
    logic [30:0] thr_plan [4];
    int          p;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ties, reloads, same-component edge
    write_threshold(31'h7FFF_FFFF);
    send(ppuf_pkg::MODE_QPERM, 10'd0, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_LOAD, 10'd0, 10'd0, 32'h8000_0000);
    send(ppuf_pkg::MODE_LOAD, 10'd1023, 10'h3FF, 32'h7FFF_FFFF);
    send(ppuf_pkg::MODE_LOAD, 10'd5, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_LOAD, 10'd6, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_LOAD, 10'd7, 10'd0, 32'h8000_0000);
    send(ppuf_pkg::MODE_LOAD, 10'd8, 10'd0, 32'h0001_0000);
    send(ppuf_pkg::MODE_QPERM, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
    send(ppuf_pkg::MODE_EDGE, 10'd5, 10'd6, 32'd0);
    send(ppuf_pkg::MODE_EDGE, 10'd8, 10'd5, 32'd0);
    send(ppuf_pkg::MODE_EDGE, 10'd6, 10'd8, 32'd0);
    send(ppuf_pkg::MODE_EDGE, 10'd0, 10'd7, 32'd0);
    send(ppuf_pkg::MODE_EDGE, 10'd7, 10'd8, 32'd0);
    send(ppuf_pkg::MODE_EDGE, 10'd1023, 10'd5, 32'd0);
    send(ppuf_pkg::MODE_QVERT, 10'd5, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_QVERT, 10'd6, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_QVERT, 10'd1023, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_LOAD, 10'd5, 10'd0, 32'hFFFF_0000);
    send(ppuf_pkg::MODE_QVERT, 10'd5, 10'd0, 32'd0);
    send(ppuf_pkg::MODE_QPERM, 10'd0, 10'd0, 32'd0);

    // random phases across several thresholds, extremes included
    thr_plan[0] = 31'd0;
    thr_plan[1] = 31'h0001_0000;
    thr_plan[2] = 31'h7FFF_FFFF;
    thr_plan[3] = 31'($urandom_range(0, 32'h0004_0000));
    for (p = 0; p < 4; p++) begin
      write_threshold(thr_plan[p]);
      while (words_sent < 20 + (p + 1) * 100) run_group();
    end

    // wait for the last results, then settle
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("persistence_pair_union_find_top verification clean");
    end else begin
      $display("persistence_pair_union_find_top verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/ppuf_pkg.sv
hw/rtl/ppuf_ram.sv
hw/rtl/ppuf_ctrl.sv
hw/rtl/ppuf_dp.sv
hw/rtl/persistence_pair_union_find_top.sv
test/testbench.sv
